// ===== hw/rtl/rwffa_pkg.sv =====
`default_nettype none

package rwffa_pkg;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_RING  = 9'b000000100,
		S_RD    = 9'b000001000,
		S_ACC   = 9'b000010000,
		S_PICK  = 9'b000100000,
		S_WRD   = 9'b001000000,
		S_WMOD  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_CLUSTER_COUNT        = 2'd0;
	localparam cfg_idx_t REG_WAVELENGTHS_PER_RING = 2'd1;

	localparam cfg_data_t CLUSTER_COUNT_RESET        = 5'd16;
	localparam cfg_data_t WAVELENGTHS_PER_RING_RESET = 5'd16;

	// result status codes
	localparam logic STATUS_GRANTED = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/rwffa_first_free.sv =====
`default_nettype none

module rwffa_first_free #(
	parameter int MAX_WAVELENGTHS = 16,
	parameter int WIDX_W          = 4
) (
	input  logic [MAX_WAVELENGTHS-1:0] used,
	input  logic [MAX_WAVELENGTHS-1:0] usable,
	output logic                       found,
	output logic [WIDX_W-1:0]          index
);

	logic [MAX_WAVELENGTHS-1:0] free_w;
	logic [MAX_WAVELENGTHS-1:0] lowest;

	// isolate the lowest free wavelength
	assign free_w = usable & ~used;
	assign lowest = free_w & (~free_w + MAX_WAVELENGTHS'(1));
	assign found  = |free_w;

	// encode the isolated bit
	always_comb begin
		index = '0;
		for (int i = 0; i < MAX_WAVELENGTHS; i++) begin
			if (lowest[i]) begin
				index = index | WIDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ring_wavelength_first_fit_allocator_core.sv =====
`default_nettype none

// First-fit wavelength allocator over a set of optical rings. Each request
// (source_cluster, target_cluster) is placed on the first opened ring, in ring
// order, that has a wavelength free on every portion of the path; even rings
// run clockwise (source to target), odd rings counter-clockwise. The lowest
// such wavelength is reserved on those portions. When no opened ring fits, a
// new ring is opened, up to MAX_RINGS; beyond that the request is refused with
// status 1, as is one whose source or target is not below the cluster count.
// Source equal to target is granted on ring 0, wavelength 0. The per-portion
// masks live in one single-port-write memory that a small sequencer walks
// one portion at a time: each tried ring reads the mask of every one of its
// L path portions (L up to cluster_count - 1), and the chosen ring then gets
// a read-modify-write pass over the same portions before the result is
// offered; the result is held while out_ready is low. After reset the
// memory is cleared, during which in_ready stays low. The block handles one
// request at a time; configuration writes are always accepted and must only
// be made while the block is idle.
module ring_wavelength_first_fit_allocator_core #(
	parameter int MAX_CLUSTERS    = 16,
	parameter int MAX_WAVELENGTHS = 16,
	parameter int MAX_RINGS       = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rwffa_pkg::cfg_idx_t  cfg_index,
	input  rwffa_pkg::cfg_data_t cfg_data,
	// requests
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          source_cluster,
	input  logic [3:0]          target_cluster,
	// results
	output logic                out_valid,
	input  logic                out_ready,
	output logic                status,
	output logic [2:0]          ring_index,
	output logic [3:0]          wavelength_index,
	output logic [3:0]          rings_in_use
);

	import rwffa_pkg::*;

	localparam int PW     = $clog2(MAX_CLUSTERS);
	localparam int NW     = $clog2(MAX_CLUSTERS + 1);
	localparam int RW     = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
	localparam int CW     = $clog2(MAX_RINGS + 1);
	localparam int WIDX_W = (MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1;
	localparam int WCW    = $clog2(MAX_WAVELENGTHS + 1);
	localparam int DEPTH  = MAX_RINGS * MAX_CLUSTERS;
	localparam int AW     = $clog2(DEPTH);

	state_t state_q;

	cfg_data_t cluster_count_q;
	cfg_data_t wavelengths_q;

	logic [NW-1:0]              n_q;
	logic [WCW-1:0]             w_q;
	logic [PW-1:0]              from_q;
	logic [PW-1:0]              to_q;
	logic [PW-1:0]              p_q;
	logic [RW-1:0]              r_q;
	logic [CW-1:0]              ring_count_q;
	logic [MAX_WAVELENGTHS-1:0] used_q;
	logic [WIDX_W-1:0]          wl_q;
	logic                       status_q;
	logic [AW-1:0]              clr_q;

	logic [MAX_WAVELENGTHS-1:0] mem_q [DEPTH];
	logic [MAX_WAVELENGTHS-1:0] rdata_q;

	logic [NW-1:0]              n_eff;
	logic [WCW-1:0]             w_eff;
	logic                       src_ok;
	logic                       dst_ok;
	logic [PW:0]                p_inc;
	logic [PW-1:0]              p_nxt;
	logic                       walk_done;
	logic [AW-1:0]              addr;
	logic                       we;
	logic [AW-1:0]              waddr;
	logic [MAX_WAVELENGTHS-1:0] wdata;
	logic [MAX_WAVELENGTHS-1:0] usable;
	logic                       pick_found;
	logic [WIDX_W-1:0]          pick_index;
	logic                       ring_cw;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// result fields
	assign status           = status_q;
	assign ring_index       = 3'(r_q);
	assign wavelength_index = 4'(wl_q);
	assign rings_in_use     = 4'(ring_count_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= CLUSTER_COUNT_RESET;
			wavelengths_q   <= WAVELENGTHS_PER_RING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLUSTER_COUNT:        cluster_count_q <= cfg_data;
				REG_WAVELENGTHS_PER_RING: wavelengths_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated register values
	always_comb begin
		if (32'(cluster_count_q) < 32'd2) begin
			n_eff = NW'(2);
		end else if (32'(cluster_count_q) > 32'(MAX_CLUSTERS)) begin
			n_eff = NW'(MAX_CLUSTERS);
		end else begin
			n_eff = NW'(cluster_count_q);
		end
		if (32'(wavelengths_q) < 32'd1) begin
			w_eff = WCW'(1);
		end else if (32'(wavelengths_q) > 32'(MAX_WAVELENGTHS)) begin
			w_eff = WCW'(MAX_WAVELENGTHS);
		end else begin
			w_eff = WCW'(wavelengths_q);
		end
	end

	assign src_ok = 32'(source_cluster) < 32'(n_eff);
	assign dst_ok = 32'(target_cluster) < 32'(n_eff);

	// next portion along the ring, wrapping at the cluster count
	assign p_inc     = {1'b0, p_q} + (PW + 1)'(1);
	assign p_nxt     = (32'(p_inc) == 32'(n_q)) ? '0 : p_inc[PW-1:0];
	assign walk_done = (p_nxt == to_q);

	assign addr    = AW'(32'(r_q) * MAX_CLUSTERS) + AW'(p_q);
	assign ring_cw = ~r_q[0];

	// usable wavelengths
	always_comb begin
		for (int i = 0; i < MAX_WAVELENGTHS; i++) begin
			usable[i] = (32'(i) < 32'(w_q));
		end
	end

	rwffa_first_free #(
		.MAX_WAVELENGTHS(MAX_WAVELENGTHS),
		.WIDX_W         (WIDX_W)
	) u_first_free (
		.used  (used_q),
		.usable(usable),
		.found (pick_found),
		.index (pick_index)
	);

	// memory write port: clearing pass or reservation update
	always_comb begin
		we    = 1'b0;
		waddr = addr;
		wdata = rdata_q | (MAX_WAVELENGTHS'(1) << wl_q);
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_WMOD) begin
			we = 1'b1;
		end
	end

	// reservation mask memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			ring_count_q <= CW'(1);
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						n_q      <= n_eff;
						w_q      <= w_eff;
						from_q   <= PW'(source_cluster);
						to_q     <= PW'(target_cluster);
						r_q      <= '0;
						wl_q     <= '0;
						status_q <= STATUS_GRANTED;
						if (!(src_ok && dst_ok)) begin
							status_q <= STATUS_REFUSED;
							state_q  <= S_OUT;
						end else if (source_cluster == target_cluster) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RING;
						end
					end
				end
				S_RING: begin
					// from/to hold source/target; odd rings walk target to source
					p_q    <= ring_cw ? from_q : to_q;
					used_q <= '0;
					if (32'(r_q) == 32'(ring_count_q)) begin
						ring_count_q <= ring_count_q + CW'(1);
					end
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					used_q <= used_q | rdata_q;
					p_q    <= p_nxt;
					state_q <= (ring_cw ? walk_done : (p_nxt == from_q)) ? S_PICK : S_RD;
				end
				S_PICK: begin
					if (pick_found) begin
						wl_q    <= pick_index;
						p_q     <= ring_cw ? from_q : to_q;
						state_q <= S_WRD;
					end else if (32'(r_q) == MAX_RINGS - 1) begin
						status_q <= STATUS_REFUSED;
						r_q      <= '0;
						state_q  <= S_OUT;
					end else begin
						r_q     <= r_q + RW'(1);
						state_q <= S_RING;
					end
				end
				S_WRD: begin
					state_q <= S_WMOD;
				end
				S_WMOD: begin
					p_q     <= p_nxt;
					state_q <= (ring_cw ? walk_done : (p_nxt == from_q)) ? S_OUT : S_WRD;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
